// ===== rtl/pkbd_pkg.sv =====
package pkbd_pkg;

    localparam int unsigned ROW_W    = 15;
    localparam int unsigned COL_W    = 15;
    localparam int unsigned CHAN_W   = 6;
    localparam int unsigned PIX_W    = ROW_W + COL_W;
    localparam int unsigned TABLE_W  = 22;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [BYTE_W-1:0]  NOOP_CODE = 8'h80;
    localparam logic [15:0]        RLE_WORD  = 16'd1;

    typedef enum logic [2:0] {
        PH_CMP_HI,
        PH_CMP_LO,
        PH_TABLE,
        PH_CONTROL,
        PH_LITERAL,
        PH_REPEAT,
        PH_IDLE
    } t_phase;

    typedef struct packed {
        logic [PIX_W-1:0]   pix_total;
        logic [TABLE_W-1:0] table_len;
        logic [CHAN_W-1:0]  chan_count;
    } t_cfg;

endpackage

// ===== rtl/packbits_channel_decoder.sv =====
// PackBits channel decoder: one byte per cycle while the output is not stalled, with no bubbles.
// A token's last byte is registered at the input, then the token is registered at the output.
// Throughput is set by the single-pass state update between the input and result
// registers; output stall backs up into the input stall.
// Reset (synchronous, active low) returns to awaiting the compression word and
// sets row, column and channel counts to 1.
module packbits_channel_decoder
    import pkbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROW_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_in_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_pixel_value,
    output logic [7:0]           o_repeat_count,
    output logic [CHAN_W-1:0]    o_channel_index,
    output logic                 o_channel_done,
    output logic                 o_image_done,
    output logic                 o_format_error
);

    t_cfg cfg;

    assign o_cfg_ready = 1'b1;

    pkbd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pkbd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_value   (o_pixel_value),
        .o_repeat_count  (o_repeat_count),
        .o_channel_index (o_channel_index),
        .o_channel_done  (o_channel_done),
        .o_image_done    (o_image_done),
        .o_format_error  (o_format_error)
    );

endmodule

// ===== rtl/pkbd_cfg.sv =====
module pkbd_cfg
    import pkbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROW_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    logic [ROW_W-1:0]   r_row_count;
    logic [COL_W-1:0]   r_column_count;
    logic [CHAN_W-1:0]  r_channel_count;
    logic [PIX_W-1:0]   pix_total;
    logic [TABLE_W-1:0] table_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= ROW_W'(1);
            r_column_count  <= COL_W'(1);
            r_channel_count <= CHAN_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:     r_row_count     <= i_cfg_data;
                CFG_COLUMN_COUNT:  r_column_count  <= i_cfg_data[COL_W-1:0];
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes follow the count registers in the cycle after the write
    always_comb begin
        pix_total = PIX_W'(r_row_count) * PIX_W'(r_column_count);
        table_len = TABLE_W'({(TABLE_W-1)'(r_row_count) * (TABLE_W-1)'(r_channel_count),
                              1'b0});
    end

    assign o_cfg = '{pix_total: pix_total, table_len: table_len,
                     chan_count: r_channel_count};

endmodule

// ===== rtl/pkbd_core.sv =====
module pkbd_core
    import pkbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_pixel_value,
    output logic [7:0]        o_repeat_count,
    output logic [CHAN_W-1:0] o_channel_index,
    output logic              o_channel_done,
    output logic              o_image_done,
    output logic              o_format_error
);

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    t_phase             r_phase, n_phase;
    logic [7:0]         r_cmp_high, n_cmp_high;
    logic [TABLE_W-1:0] r_table_left, n_table_left;
    logic [7:0]         r_literal_left, n_literal_left;
    logic [7:0]         r_run_held, n_run_held;
    logic [PIX_W-1:0]   r_pixels_left, n_pixels_left;
    logic [CHAN_W-1:0]  r_channel, n_channel;

    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_pixel_value;
    logic [7:0]         r_repeat_count;
    logic [CHAN_W-1:0]  r_channel_index;
    logic               r_channel_done, r_image_done, r_format_error;

    logic               advance, load_in, work;
    logic               emit, emit_err, emit_run;
    logic [7:0]         run_cnt;
    logic [PIX_W-1:0]   pix_eff, pix_after;
    logic               cdone, idone;
    logic [8:0]         run_len9;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign load_in    = !o_in_stall;
    assign work       = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_comb begin
        run_len9  = 9'd257 - {1'b0, r_in_byte};
        pix_eff   = (r_pixels_left == '0) ? i_cfg.pix_total : r_pixels_left;

        n_phase        = r_phase;
        n_cmp_high     = r_cmp_high;
        n_table_left   = r_table_left;
        n_literal_left = r_literal_left;
        n_run_held     = r_run_held;
        n_pixels_left  = r_pixels_left;
        n_channel      = r_channel;
        emit_err       = 1'b0;
        emit_run       = 1'b0;
        run_cnt        = 8'd1;

        case (r_phase)
            PH_CMP_HI: begin
                n_cmp_high = r_in_byte;
                n_phase    = PH_CMP_LO;
            end
            PH_CMP_LO: begin
                if ({r_cmp_high, r_in_byte} != RLE_WORD) begin
                    emit_err = 1'b1;
                    n_phase  = PH_IDLE;
                end else if (i_cfg.pix_total == '0 || i_cfg.chan_count == '0) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_table_left  = i_cfg.table_len;
                    n_pixels_left = '0;
                    n_channel     = '0;
                    n_phase       = (i_cfg.table_len == '0) ? PH_CONTROL : PH_TABLE;
                end
            end
            PH_TABLE: begin
                n_table_left = r_table_left - TABLE_W'(1);
                if (r_table_left == TABLE_W'(1)) begin
                    n_phase = PH_CONTROL;
                end
            end
            PH_CONTROL: begin
                n_pixels_left = pix_eff;
                if (pix_eff == '0) begin
                    n_phase = PH_IDLE;
                end else if (r_in_byte == NOOP_CODE) begin
                    n_phase = PH_CONTROL;
                end else if (r_in_byte < NOOP_CODE) begin
                    n_literal_left = r_in_byte + 8'd1;
                    n_phase        = PH_LITERAL;
                end else begin
                    n_run_held = run_len9[7:0];
                    n_phase    = PH_REPEAT;
                end
            end
            PH_LITERAL: begin
                n_literal_left = r_literal_left - 8'd1;
                if (r_literal_left == 8'd1) begin
                    n_phase = PH_CONTROL;
                end
                // bytes past the channel's end are swallowed
                emit_run = (r_pixels_left != '0);
                run_cnt  = 8'd1;
            end
            PH_REPEAT: begin
                n_phase = PH_CONTROL;
                if (PIX_W'(r_run_held) > r_pixels_left) begin
                    run_cnt = r_pixels_left[7:0];
                end else begin
                    run_cnt = r_run_held;
                end
                emit_run = (run_cnt != 8'd0);
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        pix_after = r_pixels_left - PIX_W'(run_cnt);
        cdone     = (pix_after == '0);
        idone     = cdone && (({1'b0, r_channel} + 7'd1) >= {1'b0, i_cfg.chan_count});
        if (emit_run) begin
            n_pixels_left = pix_after;
            if (idone) begin
                n_phase = PH_IDLE;
            end else if (cdone) begin
                n_channel = r_channel + CHAN_W'(1);
            end
        end
        emit = emit_err || emit_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_CMP_HI;
            r_cmp_high     <= '0;
            r_table_left   <= '0;
            r_literal_left <= '0;
            r_run_held     <= '0;
            r_pixels_left  <= '0;
            r_channel      <= '0;
        end else if (work) begin
            r_phase        <= n_phase;
            r_cmp_high     <= n_cmp_high;
            r_table_left   <= n_table_left;
            r_literal_left <= n_literal_left;
            r_run_held     <= n_run_held;
            r_pixels_left  <= n_pixels_left;
            r_channel      <= n_channel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= work && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work && emit) begin
            if (emit_err) begin
                r_pixel_value   <= '0;
                r_repeat_count  <= '0;
                r_channel_index <= '0;
                r_channel_done  <= 1'b0;
                r_image_done    <= 1'b0;
                r_format_error  <= 1'b1;
            end else begin
                r_pixel_value   <= r_in_byte;
                r_repeat_count  <= run_cnt;
                r_channel_index <= r_channel;
                r_channel_done  <= cdone;
                r_image_done    <= idone;
                r_format_error  <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_value   = r_pixel_value;
    assign o_repeat_count  = r_repeat_count;
    assign o_channel_index = r_channel_index;
    assign o_channel_done  = r_channel_done;
    assign o_image_done    = r_image_done;
    assign o_format_error  = r_format_error;

endmodule

// ===== tb/sv/packbits_channel_decoder_test.sv =====
`timescale 1ns / 1ps

module packbits_channel_decoder_test;
    import pkbd_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int ROW_LEN_BYTES = 2;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic [7:0]        count;
        logic [CHAN_W-1:0] channel;
        logic              chan_done;
        logic              img_done;
        logic              fmt_err;
    } t_run_token;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ROW_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_in_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [BYTE_W-1:0]    o_pixel_value;
    logic [7:0]           o_repeat_count;
    logic [CHAN_W-1:0]    o_channel_index;
    logic                 o_channel_done;
    logic                 o_image_done;
    logic                 o_format_error;

    packbits_channel_decoder dut (.*);

    always #1 i_clk = ~i_clk;

    // decoder state as predicted from the accepted byte stream
    logic [ROW_W-1:0]   cfg_rows;
    logic [COL_W-1:0]   cfg_cols;
    logic [CHAN_W-1:0]  cfg_chans;
    t_phase             dec_phase;
    logic [BYTE_W-1:0]  cmp_high;
    logic [TABLE_W-1:0] table_left;
    logic [7:0]         lit_left;
    logic [7:0]         run_held;
    logic [PIX_W-1:0]   pix_left;
    logic [CHAN_W-1:0]  dec_chan;

    t_run_token expected_tokens[$];

    int idle_pct;
    int hold_cycles;
    int bytes_sent;
    int tokens_checked;
    int channels_done;
    int images_done;
    int mismatches;

    task automatic emit_run(input logic [BYTE_W-1:0] value, input logic [PIX_W-1:0] count);
        logic cdone;
        logic idone;
        pix_left = pix_left - count;
        cdone = (pix_left == '0);
        idone = cdone && (32'(dec_chan) + 1 >= 32'(cfg_chans));
        expected_tokens.push_back('{pixel: value, count: 8'(count), channel: dec_chan,
                                    chan_done: cdone, img_done: idone, fmt_err: 1'b0});
        if (idone)
            dec_phase = PH_IDLE;
        else if (cdone)
            dec_chan = dec_chan + 1'b1;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [PIX_W-1:0] n;
        case (dec_phase)
            PH_CMP_HI: begin
                cmp_high  = b;
                dec_phase = PH_CMP_LO;
            end
            PH_CMP_LO: begin
                if ({cmp_high, b} != RLE_WORD) begin
                    expected_tokens.push_back('{pixel: '0, count: '0, channel: '0,
                                                chan_done: 1'b0, img_done: 1'b0,
                                                fmt_err: 1'b1});
                    dec_phase = PH_IDLE;
                end else if (PIX_W'(cfg_rows) * PIX_W'(cfg_cols) == '0 || cfg_chans == '0) begin
                    dec_phase = PH_IDLE;
                end else begin
                    table_left = TABLE_W'(32'(cfg_rows) * cfg_chans * ROW_LEN_BYTES);
                    pix_left   = '0;
                    dec_chan   = '0;
                    dec_phase  = (table_left == '0) ? PH_CONTROL : PH_TABLE;
                end
            end
            PH_TABLE: begin
                table_left = table_left - 1'b1;
                if (table_left == '0)
                    dec_phase = PH_CONTROL;
            end
            PH_CONTROL: begin
                // channel size is latched by the first control byte of each channel
                if (pix_left == '0) begin
                    pix_left = PIX_W'(cfg_rows) * PIX_W'(cfg_cols);
                    if (pix_left == '0)
                        dec_phase = PH_IDLE;
                end
                if (dec_phase == PH_CONTROL && b != NOOP_CODE) begin
                    if (b < NOOP_CODE) begin
                        lit_left  = b + 1'b1;
                        dec_phase = PH_LITERAL;
                    end else begin
                        // 1 - signed(b), i.e. 257 - b for b in 129..255
                        run_held  = 8'(9'd257 - {1'b0, b});
                        dec_phase = PH_REPEAT;
                    end
                end
            end
            PH_LITERAL: begin
                lit_left = lit_left - 1'b1;
                if (lit_left == '0)
                    dec_phase = PH_CONTROL;
                // bytes past the channel end are swallowed
                if (pix_left != '0)
                    emit_run(b, PIX_W'(1));
            end
            PH_REPEAT: begin
                n = PIX_W'(run_held);
                if (n > pix_left)
                    n = pix_left;
                dec_phase = PH_CONTROL;
                if (n != '0)
                    emit_run(b, n);
            end
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_byte(value);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= ROW_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_ROW_COUNT:     cfg_rows  = ROW_W'(value);
            CFG_COLUMN_COUNT:  cfg_cols  = COL_W'(value);
            CFG_CHANNEL_COUNT: cfg_chans = CHAN_W'(value);
            default: ;
        endcase
    endtask

    // zero leaves a register untouched; writes only once the decoder has gone quiet
    task automatic program_sizes(input int rows, input int cols, input int chans);
        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (rows != 0)
            write_reg(CFG_ROW_COUNT, rows);
        if (cols != 0)
            write_reg(CFG_COLUMN_COUNT, cols);
        if (chans != 0)
            write_reg(CFG_CHANNEL_COUNT, chans);
        i_cfg_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_packet(input bit long_runs);
        int kind;
        int len;
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            send_byte(NOOP_CODE);
        end else if (long_runs ? kind < 15 : kind < 8) begin
            if (long_runs)
                len = $urandom_range(100, 128);
            else
                len = (kind == 1) ? 128 : $urandom_range(2, 9);
            send_byte(8'(257 - len));
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            len = (!long_runs && kind == 15) ? $urandom_range(1, 128) : $urandom_range(1, 8);
            send_byte(8'(len - 1));
            repeat (len) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // whole packets until the current channel (or the image) is complete
    task automatic send_channel(input bit long_runs);
        logic [CHAN_W-1:0] start_chan;
        start_chan = dec_chan;
        while (dec_chan == start_chan && dec_phase != PH_IDLE)
            send_packet(long_runs);
    endtask

    task automatic test_header();
        program_sizes(1, 4, 56);
        idle_pct = 4;
        send_byte(RLE_WORD[15:8]);
        send_byte(RLE_WORD[7:0]);
        while (dec_phase == PH_TABLE)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // 4-pixel channels: no-ops, literal, short run, clipped run, literal past channel end
    task automatic test_directed_runs();
        logic [BYTE_W-1:0] seq[$];
        seq = '{NOOP_CODE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h81, 8'hAA,
                8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
                NOOP_CODE, NOOP_CODE, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'h55};
        idle_pct = 0;
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_output_hold_off();
        program_sizes(2, 100, 0);
        idle_pct    = 0;
        hold_cycles = 80;
        // longest literal, offered back to back against a held receiver
        send_byte(8'h7F);
        repeat (128) send_byte(8'($urandom_range(0, 255)));
        send_channel(1'b0);
    endtask

    // channel count moves about but stays above any channel reached here
    task automatic test_random_channels();
        while (bytes_sent < 400 && dec_chan < 48) begin
            if ($urandom_range(0, 1))
                program_sizes($urandom_range(1, 6), $urandom_range(1, 12),
                              ($urandom_range(0, 2) == 0) ? $urandom_range(50, 56) : 0);
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 4;
                2:       idle_pct = 12;
                default: idle_pct = 25;
            endcase
            send_channel(1'b0);
        end
    endtask

    task automatic test_max_sizes();
        program_sizes(30000, 1, 56);
        idle_pct = 8;
        send_channel(1'b1);
        program_sizes(1, 30000, 0);
        idle_pct = 3;
        send_channel(1'b1);
    endtask

    // channel count dropped below the channel in progress: a literal runs past the
    // image end and the trailing bytes are ignored
    task automatic test_last_channel();
        program_sizes(1, 3, 1);
        idle_pct = 0;
        send_byte(8'h05);
        repeat (6) send_byte(8'($urandom_range(0, 255)));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(NOOP_CODE);
        send_byte(8'h81);
    endtask

    initial begin : receiver
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : token_check
        t_run_token got;
        t_run_token want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = '{pixel: o_pixel_value, count: o_repeat_count,
                        channel: o_channel_index, chan_done: o_channel_done,
                        img_done: o_image_done, fmt_err: o_format_error};
                tokens_checked++;
                if (got.chan_done)
                    channels_done++;
                if (got.img_done)
                    images_done++;
                if (expected_tokens.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected token: value %h count %0d ch %0d cd %b id %b fe %b",
                                 got.pixel, got.count, got.channel, got.chan_done,
                                 got.img_done, got.fmt_err);
                    mismatches++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.pixel !== want.pixel || got.count !== want.count ||
                        got.channel !== want.channel || got.chan_done !== want.chan_done ||
                        got.img_done !== want.img_done || got.fmt_err !== want.fmt_err) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("token %0d mismatch at %0t", tokens_checked, $realtime);
                            $display("  exp: value %h count %0d ch %0d cd %b id %b fe %b",
                                     want.pixel, want.count, want.channel, want.chan_done,
                                     want.img_done, want.fmt_err);
                            $display("  got: value %h count %0d ch %0d cd %b id %b fe %b",
                                     got.pixel, got.count, got.channel, got.chan_done,
                                     got.img_done, got.fmt_err);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #1_000_000;
        $display("packbits_channel_decoder verification failed");
        $finish;
    end

    initial begin : run
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ROW_COUNT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_byte   <= '0;
        idle_pct    = 0;
        hold_cycles = 0;
        bytes_sent  = 0;
        tokens_checked = 0;
        channels_done  = 0;
        images_done    = 0;
        mismatches     = 0;
        cfg_rows   = ROW_W'(1);
        cfg_cols   = COL_W'(1);
        cfg_chans  = CHAN_W'(1);
        dec_phase  = PH_CMP_HI;
        cmp_high   = '0;
        table_left = '0;
        lit_left   = '0;
        run_held   = '0;
        pix_left   = '0;
        dec_chan   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header();
        test_directed_runs();
        test_output_hold_off();
        test_random_channels();
        test_max_sizes();
        test_last_channel();

        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run covered %0d bytes and %0d tokens over %0d completed channels",
                 bytes_sent, tokens_checked, channels_done);
        $display("incl. 30000-pixel channels, clipped runs, literal overrun, image end seen %0d",
                 images_done);
        if (mismatches == 0)
            $display("packbits_channel_decoder verification clean");
        else
            $display("packbits_channel_decoder verification failed");
        $finish;
    end

endmodule
